/* src/wgm_pkg.sv */
package wgm_pkg;

  localparam int unsigned MaxPatternDefault = 64;

  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] AnyByte  = 8'h3F;
  localparam logic [8:0] CaseGap  = 9'd32;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

  function automatic logic bytes_agree(logic [7:0] p, logic [7:0] t);
    logic [8:0] d;
    d = {1'b0, p} - {1'b0, t};
    return (d == 9'd0) || (d == CaseGap) || (d == (9'd0 - CaseGap));
  endfunction

endpackage

/* src/wildcard_glob_matcher_core.sv */
// wildcard glob matcher
//
// input stream s_axis: tuser carries the item kind (pattern byte, text byte,
// finish), tdata carries the byte. pattern bytes come first, then text bytes,
// then one finish request, which returns one result on m_axis:
// tdata bit 0 is the match flag, bit 1 flags pattern bytes dropped as overflow.
//
// a pattern byte or a finish is handled while idle; the finish result shows
// on the output register the cycle after. a text byte starts a sweep over
// the pattern: the pattern and its prefix match bits sit in one memory with a
// registered read, and the sweep reads one entry and writes it back each
// cycle. a text byte with an empty pattern needs no sweep.
//
// after reset the pattern is empty and no memory clearing is needed; entries
// are written before they are read. a stalled result holds on m_axis and
// every new request waits until that result is taken.
module wildcard_glob_matcher_core #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MaxPatternDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // ch [7:0]
  input  logic [1:0] s_axis_tuser_i,   // kind [1:0]
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // matched [0], pattern_overflow [1], zero [7:2]
);
  import wgm_pkg::*;

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_PATTERN);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          begun_q, begun_d;
  logic          ovf_q, ovf_d;
  logic          last_q, last_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          old_prev_q, old_prev_d;
  logic          new_prev_q, new_prev_d;
  logic [7:0]    ch_q, ch_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_data_q, out_data_d;

  logic [8:0]    mem_q [MAX_PATTERN];
  logic [8:0]    rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [8:0]    wr_data;

  logic          in_fire;
  logic          out_fire;
  logic          star_here;
  logic          nv;
  logic          sweep_done;

  assign out_fire  = out_valid_q && m_axis_tready_i;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign star_here = (rd_data_q[8:1] == StarByte);
  assign sweep_done = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    if (star_here) begin
      nv = new_prev_q || rd_data_q[0];
    end else if ((rd_data_q[8:1] == AnyByte) || bytes_agree(rd_data_q[8:1], ch_q)) begin
      nv = old_prev_q;
    end else begin
      nv = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    begun_d     = begun_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    idx_d       = idx_q;
    old_prev_d  = old_prev_q;
    new_prev_d  = new_prev_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_fire;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rd_data_q;
    rd_addr     = '0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = !out_valid_q || m_axis_tready_i;
        if (in_fire) begin
          unique case (s_axis_tuser_i)
            KIND_PATTERN: begin
              if (!begun_q) begin
                if (count_q >= MaxCount) begin
                  ovf_d = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = count_q[AW-1:0];
                  wr_data = {s_axis_tdata_i, last_q && (s_axis_tdata_i == StarByte)};
                  last_d  = last_q && (s_axis_tdata_i == StarByte);
                  count_d = count_q + CW'(1);
                end
              end
            end
            KIND_TEXT: begin
              if (count_q == '0) begin
                begun_d = 1'b1;
                last_d  = 1'b0;
              end else begin
                old_prev_d = !begun_q;
                new_prev_d = 1'b0;
                ch_d       = s_axis_tdata_i;
                idx_d      = '0;
                state_d    = ST_SWEEP;
              end
            end
            KIND_FINISH: begin
              out_valid_d = 1'b1;
              out_data_d  = {ovf_q, last_q};
              count_d     = '0;
              begun_d     = 1'b0;
              ovf_d       = 1'b0;
              last_d      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        rd_addr    = idx_q + AW'(1);
        wr_en      = 1'b1;
        wr_addr    = idx_q;
        wr_data    = {rd_data_q[8:1], nv};
        new_prev_d = nv;
        old_prev_d = rd_data_q[0];
        if (sweep_done) begin
          last_d  = nv;
          begun_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      begun_q     <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      begun_q     <= begun_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_prev_q <= old_prev_d;
    new_prev_q <= new_prev_d;
    ch_q       <= ch_d;
    out_data_q <= out_data_d;
  end

  // pattern and prefix bit memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_data_q};

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (CW'(idx_q) < count_q))
    else $error("sweep index past pattern length");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !s_axis_tready_o)
    else $error("input accepted during sweep");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser_i == KIND_FINISH)) |=>
      (m_axis_tvalid_o && (count_q == '0) && !begun_q && !ovf_q && last_q))
    else $error("finish did not report and clear");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("pattern count beyond capacity");

endmodule
